/* hw/rtl/md5h_pkg.sv */
package md5h_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } md5h_in_t;

    typedef struct packed {
        logic [63:0] digest_first_half;
        logic [63:0] digest_second_half;
    } md5h_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md5h_stat_t;

    localparam int unsigned WORDS   = 16;
    localparam int unsigned WORD_AW = 4;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [3:0] LEN_LO_IDX = 4'd14;
    localparam logic [3:0] LEN_HI_IDX = 4'd15;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMOUNT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [3:0] word_index(input logic [5:0] r);
        logic [3:0] rl;
        logic [3:0] idx;
        rl = r[3:0];
        case (r[5:4])
            2'd0: begin
                idx = rl;
            end
            2'd1: begin
                idx = 4'(rl * 4'd5 + 4'd1);
            end
            2'd2: begin
                idx = 4'(rl * 4'd3 + 4'd5);
            end
            default: begin
                idx = 4'(rl * 4'd7);
            end
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] round_func(input logic [5:0] r, input logic [31:0] b,
                                               input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (r[5:4])
            2'd0: begin
                f = (b & c) | (~b & d);
            end
            2'd1: begin
                f = (b & d) | (c & ~d);
            end
            2'd2: begin
                f = b ^ c ^ d;
            end
            default: begin
                f = c ^ (b | ~d);
            end
        endcase
        return f;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        return ROT_AMOUNT[{r[5:4], r[1:0]}];
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

endpackage

/* hw/rtl/md5h_ram.sv */
module md5h_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/md5h_core.sv */
module md5h_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [3:0][31:0]    chain_in,
    output logic [3:0]          rd_addr,
    input  logic [31:0]         rd_data,
    output logic [3:0][31:0]    state_out,
    output md5h_pkg::md5h_stat_t stat
);

    import md5h_pkg::*;

    logic        active_reg, active_next;
    logic        done_reg, done_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [31:0] sum;
    logic [31:0] new_b;

    always_comb begin
        sum   = a_reg + round_func(rnd_reg, b_reg, c_reg, d_reg) + ROUND_CONST[rnd_reg] + rd_data;
        new_b = b_reg + rotl(sum, rot_amount(rnd_reg));

        rd_addr = word_index(start ? 6'd0 : 6'(rnd_reg + 6'd1));

        active_next = active_reg;
        done_next   = 1'b0;
        rnd_next    = rnd_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;

        if (start) begin
            active_next = 1'b1;
            rnd_next    = '0;
            a_next      = chain_in[0];
            b_next      = chain_in[1];
            c_next      = chain_in[2];
            d_next      = chain_in[3];
        end else if (active_reg) begin
            a_next   = d_reg;
            d_next   = c_reg;
            c_next   = b_reg;
            b_next   = new_b;
            rnd_next = 6'(rnd_reg + 6'd1);
            if (rnd_reg == LAST_ROUND) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            rnd_reg    <= '0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
            rnd_reg    <= rnd_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    assign state_out = {d_reg, c_reg, b_reg, a_reg};
    assign stat.busy = active_reg | done_reg;
    assign stat.done = done_reg;

endmodule

/* hw/rtl/md5_hash_stream.sv */
// Streaming MD5 hasher: at most one message byte per input transaction, digest of the whole
// message as one output transaction after the transaction that carries end_of_message. A byte
// that completes a 64-byte block starts the compression, which runs one round per cycle on a
// single round unit reading the message words from a 16 x 32 block memory, while s_ready
// stays low. An end of message writes the padding one word per cycle and compresses once,
// or twice when the length no longer fits in the current block, then loads the output
// register; s_ready stays low until then, and longer while an earlier digest still waits in
// the output register. The output register lets the next message start while a digest still
// waits on m_ready.
module md5_hash_stream (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  md5h_pkg::md5h_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output md5h_pkg::md5h_out_t  m_data
);

    import md5h_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_COMP = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [63:0]     cnt_reg, cnt_next;
    logic [63:0]     cnt_inc;
    logic [31:0]     word_reg, word_next;
    logic [3:0]      pad_idx_reg, pad_idx_next;
    logic            first_reg, first_next;
    logic            marker_done_reg, marker_done_next;
    logic            extra_reg, extra_next;
    logic            end_pend_reg, end_pend_next;
    logic            final_reg, final_next;
    logic [3:0][31:0] h_reg, h_next;
    logic            m_valid_reg, m_valid_next;
    md5h_out_t       m_data_reg, m_data_next;

    logic [1:0]      lane;
    logic [31:0]     ins_word;
    logic [31:0]     mark_word;
    logic [31:0]     pad_word;
    logic [63:0]     len_bits;

    logic            ram_we;
    logic [3:0]      ram_waddr;
    logic [31:0]     ram_wdata;
    logic [3:0]      ram_raddr;
    logic [31:0]     ram_rdata;

    logic            core_start;
    logic [3:0][31:0] core_state;
    md5h_stat_t      core_stat;

    md5h_ram #(
        .WIDTH(32),
        .DEPTH(WORDS)
    ) u_block_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    md5h_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (core_start),
        .chain_in  (h_reg),
        .rd_addr   (ram_raddr),
        .rd_data   (ram_rdata),
        .state_out (core_state),
        .stat      (core_stat)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        lane     = cnt_reg[1:0];
        cnt_inc  = cnt_reg + 64'd1;
        len_bits = {cnt_reg[60:0], 3'b000};
        for (int i = 0; i < 4; i++) begin
            ins_word[8*i +: 8]  = (lane == 2'(i)) ? s_data.data_byte : word_reg[8*i +: 8];
            if (2'(i) < lane) begin
                mark_word[8*i +: 8] = word_reg[8*i +: 8];
            end else if (2'(i) == lane) begin
                mark_word[8*i +: 8] = PAD_MARKER;
            end else begin
                mark_word[8*i +: 8] = 8'h00;
            end
        end
        if (first_reg) begin
            pad_word = mark_word;
        end else if (!extra_reg && pad_idx_reg == LEN_LO_IDX) begin
            pad_word = len_bits[31:0];
        end else if (!extra_reg && pad_idx_reg == LEN_HI_IDX) begin
            pad_word = len_bits[63:32];
        end else begin
            pad_word = '0;
        end
    end

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        word_next        = word_reg;
        pad_idx_next     = pad_idx_reg;
        first_next       = first_reg;
        marker_done_next = marker_done_reg;
        extra_next       = extra_reg;
        end_pend_next    = end_pend_reg;
        final_next       = final_reg;
        h_next           = h_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        core_start       = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = pad_idx_reg;
        ram_wdata        = pad_word;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    marker_done_next = 1'b0;
                    extra_next       = 1'b0;
                    final_next       = 1'b0;
                    end_pend_next    = s_data.end_of_message;
                    if (s_data.byte_present) begin
                        word_next = ins_word;
                        cnt_next  = cnt_inc;
                        if (lane == 2'd3) begin
                            ram_we    = 1'b1;
                            ram_waddr = cnt_reg[5:2];
                            ram_wdata = ins_word;
                        end
                        if (cnt_reg[5:0] == 6'd63) begin
                            core_start = 1'b1;
                            state_next = ST_COMP;
                        end else if (s_data.end_of_message) begin
                            state_next   = ST_PAD;
                            pad_idx_next = cnt_inc[5:2];
                            first_next   = 1'b1;
                        end
                    end else if (s_data.end_of_message) begin
                        state_next   = ST_PAD;
                        pad_idx_next = cnt_reg[5:2];
                        first_next   = 1'b1;
                    end
                end
            end
            ST_PAD: begin
                ram_we       = 1'b1;
                pad_idx_next = 4'(pad_idx_reg + 4'd1);
                if (first_reg) begin
                    first_next       = 1'b0;
                    marker_done_next = 1'b1;
                    extra_next       = (pad_idx_reg >= LEN_LO_IDX);
                end
                if (pad_idx_reg == LEN_HI_IDX) begin
                    core_start = 1'b1;
                    state_next = ST_COMP;
                    final_next = !first_reg && !extra_reg;
                end
            end
            ST_COMP: begin
                if (core_stat.done) begin
                    for (int i = 0; i < 4; i++) begin
                        h_next[i] = h_reg[i] + core_state[i];
                    end
                    if (!end_pend_reg) begin
                        state_next = ST_IDLE;
                    end else if (final_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next   = ST_PAD;
                        pad_idx_next = '0;
                        first_next   = !marker_done_reg;
                        extra_next   = 1'b0;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                   = 1'b1;
                    m_data_next.digest_first_half  = {h_reg[1], h_reg[0]};
                    m_data_next.digest_second_half = {h_reg[3], h_reg[2]};
                    h_next        = {IV_D, IV_C, IV_B, IV_A};
                    cnt_next      = '0;
                    end_pend_next = 1'b0;
                    final_next    = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            pad_idx_reg     <= '0;
            first_reg       <= 1'b0;
            marker_done_reg <= 1'b0;
            extra_reg       <= 1'b0;
            end_pend_reg    <= 1'b0;
            final_reg       <= 1'b0;
            h_reg           <= {IV_D, IV_C, IV_B, IV_A};
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            pad_idx_reg     <= pad_idx_next;
            first_reg       <= first_next;
            marker_done_reg <= marker_done_next;
            extra_reg       <= extra_next;
            end_pend_reg    <= end_pend_next;
            final_reg       <= final_next;
            h_reg           <= h_next;
            m_valid_reg     <= m_valid_next;
        end
        word_reg   <= word_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    a_ready_core_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !core_stat.busy)
        else $error("transaction accepted while round unit busy");

    a_done_in_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        core_stat.done |-> (state_reg == ST_COMP))
        else $error("compression finished outside compress state");

    a_final_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        final_reg |-> end_pend_reg)
        else $error("final block flagged without pending end of message");

    a_extra_after_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        extra_reg |-> marker_done_reg)
        else $error("extra pad block without marker byte");

    a_out_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("digest not loaded into output register");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import md5h_pkg::*;

    localparam int N_ITEMS     = 950;
    localparam int TAIL_ITEMS  = 100;
    localparam int DRAIN_WAIT  = 200;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [31:0] INIT_WORD [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] SINE_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int SHIFT_TABLE [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    localparam int PAD_LENGTHS [11] = '{55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128};

    class md5_digest_board;
        logic [31:0] chain [4];
        logic [7:0]  blk [64];
        logic [63:0] nbytes;
        md5h_out_t   digests_due [$];
        int unsigned fails;

        function new();
            int i;
            for (i = 0; i < 64; i++) begin
                blk[i] = 8'h00;
            end
            fails = 0;
            restart();
        endfunction

        function void restart();
            int i;
            for (i = 0; i < 4; i++) begin
                chain[i] = INIT_WORD[i];
            end
            nbytes = 64'd0;
        endfunction

        function void compress();
            logic [31:0] w [16];
            logic [31:0] a, b, c, d, f, t, s;
            int i, r, k, sh;
            for (i = 0; i < 16; i++) begin
                w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
            end
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (r = 0; r < 64; r++) begin
                if (r < 16) begin
                    f = (b & c) | (~b & d);
                    k = r;
                end else if (r < 32) begin
                    f = (b & d) | (c & ~d);
                    k = (5 * r + 1) % 16;
                end else if (r < 48) begin
                    f = b ^ c ^ d;
                    k = (3 * r + 5) % 16;
                end else begin
                    f = c ^ (b | ~d);
                    k = (7 * r) % 16;
                end
                sh = SHIFT_TABLE[((r / 16) * 4) + (r % 4)];
                s = a + f + SINE_TABLE[r] + w[k];
                t = d;
                d = c;
                c = b;
                b = b + ((s << sh) | (s >> (32 - sh)));
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void note_input(md5h_in_t t);
            int unsigned pos;
            logic [63:0] bits;
            md5h_out_t dg;
            int i;
            if (t.byte_present) begin
                pos = 32'(nbytes[5:0]);
                blk[pos] = t.data_byte;
                nbytes++;
                if (pos == 63) begin
                    compress();
                end
            end
            if (!t.end_of_message) begin
                return;
            end
            bits = nbytes << 3;
            pos = 32'(nbytes[5:0]);
            blk[pos] = 8'h80;
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress();
                pos = 0;
            end
            while (pos < 56) begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (i = 0; i < 8; i++) begin
                blk[56+i] = bits[8*i +: 8];
            end
            compress();
            dg.digest_first_half  = {chain[1], chain[0]};
            dg.digest_second_half = {chain[3], chain[2]};
            digests_due.push_back(dg);
            restart();
        endfunction

        function void check_digest(md5h_out_t got);
            md5h_out_t want;
            if (digests_due.size() == 0) begin
                $error("digest with none expected: %h %h",
                       got.digest_first_half, got.digest_second_half);
                fails++;
                return;
            end
            want = digests_due.pop_front();
            if (got.digest_first_half !== want.digest_first_half) begin
                $error("digest_first_half: expected %h, actual %h",
                       want.digest_first_half, got.digest_first_half);
                fails++;
            end
            if (got.digest_second_half !== want.digest_second_half) begin
                $error("digest_second_half: expected %h, actual %h",
                       want.digest_second_half, got.digest_second_half);
                fails++;
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    md5h_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    md5h_out_t m_data;

    md5_digest_board board;
    int  items_sent = 0;
    int  cycle_count = 0;
    int  ready_hold = 0;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;
    bit  quiet_tail = 1'b0;

    md5_hash_stream u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            board.note_input(s_data);
        end
        if (aresetn && m_valid && m_ready) begin
            board.check_digest(m_data);
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if (stalls_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
            ready_hold <= $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
        if ($urandom_range(0, 299) == 0) begin
            stalls_on <= ~stalls_on;
        end
    end

    task automatic pause(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic send_item(input md5h_in_t item);
        if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
            pause($urandom_range(1, 3));
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (item.byte_present || item.end_of_message) begin
            items_sent++;
        end
        if (items_sent >= N_ITEMS - TAIL_ITEMS) begin
            quiet_tail = 1'b1;
        end
    endtask

    task automatic send_bytes(input logic [7:0] val, input bit present, input bit last);
        md5h_in_t item;
        item.data_byte      = val;
        item.byte_present   = present;
        item.end_of_message = last;
        send_item(item);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.digests_due.size() != 0);
    endtask

    initial begin
        int len, kind, i;
        bit bare;
        board = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty message, idle transaction, single-byte extremes
        send_bytes(8'hff, 1'b0, 1'b1);
        send_bytes(8'h00, 1'b0, 1'b0);
        send_bytes(8'h00, 1'b1, 1'b1);
        send_bytes(8'hff, 1'b1, 1'b1);
        // "abc"
        send_bytes(8'h61, 1'b1, 1'b0);
        send_bytes(8'h62, 1'b1, 1'b0);
        send_bytes(8'h63, 1'b1, 1'b1);
        // bytes then bare end
        send_bytes(8'h80, 1'b1, 1'b0);
        send_bytes(8'h7f, 1'b1, 1'b0);
        send_bytes(8'h5a, 1'b0, 1'b1);
        // idle transaction inside a message
        send_bytes(8'h55, 1'b1, 1'b0);
        send_bytes(8'hff, 1'b0, 1'b0);
        send_bytes(8'haa, 1'b1, 1'b1);
        wait_drained();

        while (items_sent < N_ITEMS) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 2) == 0) begin
                gaps_on = ~gaps_on;
            end
            if (kind == 9) begin
                // noise
                repeat ($urandom_range(1, 3)) send_bytes(8'($urandom), 1'b0, 1'b0);
            end else begin
                if (kind <= 6) begin
                    len = $urandom_range(0, 12);
                end else begin
                    len = PAD_LENGTHS[$urandom_range(0, 10)];
                end
                bare = (len == 0) || ($urandom_range(0, 1) == 0);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        send_bytes(8'($urandom), 1'b0, 1'b0);
                    end
                    send_bytes(8'($urandom), 1'b1, !bare && i == len - 1);
                end
                if (bare) begin
                    send_bytes(8'($urandom), 1'b0, 1'b1);
                end
                if ($urandom_range(0, 7) == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (board.fails == 0 && board.digests_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
